// File: design/dfsta_pkg.sv
// Shared types and codes for the DFS timestamp ancestor query unit.
// No dependencies.
package dfsta_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic KIND_RUN   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam int CMD_W  = 2;
	localparam int VTX_W  = 11;

endpackage

// File: design/dfs_timestamp_ancestor_query_unit.sv
// DFS timestamp ancestor query unit: forest loader, stack-based depth-first walk
// and proper-ancestor test on stored entry/exit times. Depends on dfsta_pkg.
//
// An item is taken when start is high and busy is low; busy stays high until the
// item is finished. A load with a valid parent passes through S_LOAD2 and S_LOAD3;
// a root load, an ignored load or a query with a range error never raises busy; a
// query reads both times, then decides; a run sweeps the time memories, fetches the
// root, then walks with one read-then-decide step per child-list entry scanned and
// a finish step and, below the root, a pop per vertex finished, as each step waits
// on one synchronous memory read. After reset the unit clears child heads and times
// with busy high; configuration writes are taken at any time. Run and query results
// appear on kind, is_ancestor and range_error for exactly one cycle with done high
// and must be captured then; busy is already low in that cycle.
module dfs_timestamp_ancestor_query_unit
	import dfsta_pkg::*;
#(
	parameter int MAX_VERTICES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [VTX_W-1:0]    first_vertex,
	input  logic [VTX_W-1:0]    second_vertex,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [VTX_W-1:0]    cfg_data,
	output logic                done,
	output logic                kind,
	output logic                is_ancestor,
	output logic                range_error
);

	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (VW > VTX_W) ? VW : VTX_W;
	localparam int TW = $clog2(2 * MAX_VERTICES + 2);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD2,
		S_LOAD3,
		S_QUERY,
		S_CLEAR,
		S_ROOT,
		S_ROOT2,
		S_SCAN,
		S_TEST,
		S_POP
	} state_t;

	state_t          state_q;
	logic [VTX_W-1:0] vc_q;
	logic [VW-1:0]   root_q;
	logic [VW-1:0]   c_q;
	logic [VW-1:0]   p_q;
	logic [VW-1:0]   clr_q;
	logic            clr_head_q;
	logic [TW-1:0]   time_q;
	logic [VW-1:0]   sp_q;
	logic [VW-1:0]   top_v_q;
	logic [VW-1:0]   top_nc_q;
	logic            done_q;
	logic            kind_q;
	logic            anc_q;
	logic            err_q;

	logic [CW-1:0]   lc;
	logic [VW-1:0]   rd0;
	logic [VW-1:0]   rd1;
	logic [VW-1:0]   stk_ra;
	logic            push;

	logic            head_we;
	logic [VW-1:0]   head_wa;
	logic [VW-1:0]   head_wd;
	logic            tail_we;
	logic            nsib_we;
	logic [VW-1:0]   nsib_wa;
	logic [VW-1:0]   nsib_wd;
	logic            disc_we;
	logic [VW-1:0]   disc_wa;
	logic [TW-1:0]   disc_wd;
	logic            fin_we;
	logic [VW-1:0]   fin_wa;
	logic [TW-1:0]   fin_wd;
	logic            stk_we;

	logic [VW-1:0]   head_mem [0:MAX_VERTICES];
	logic [VW-1:0]   tail_mem [0:MAX_VERTICES];
	logic [VW-1:0]   nsib_mem [0:MAX_VERTICES];
	logic [TW-1:0]   disc_mem [0:MAX_VERTICES];
	logic [TW-1:0]   fin_mem  [0:MAX_VERTICES];
	logic [2*VW-1:0] stk_mem  [0:MAX_VERTICES];

	logic [VW-1:0]   head_rd_q;
	logic [VW-1:0]   tail_rd_q;
	logic [VW-1:0]   nsib_rd_q;
	logic [TW-1:0]   disc_rd0_q;
	logic [TW-1:0]   disc_rd1_q;
	logic [TW-1:0]   fin_rd0_q;
	logic [TW-1:0]   fin_rd1_q;
	logic [2*VW-1:0] stk_rd_q;

	function automatic logic rng(input logic [CW-1:0] v, input logic [CW-1:0] lim);
		return (v != '0) && (v <= lim);
	endfunction

	assign lc = (CW'(vc_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_q);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign kind = kind_q;
	assign is_ancestor = anc_q;
	assign range_error = err_q;

	assign push = (state_q == S_TEST) && rng(CW'(top_nc_q), lc) && (disc_rd0_q == '0);
	assign stk_ra = sp_q - VW'(2);
	assign rd1 = VW'(second_vertex);

	always_comb begin
		rd0 = VW'(first_vertex);
		unique case (state_q)
			S_IDLE:  rd0 = (cmd_t'(cmd) == CMD_LOAD) ? VW'(second_vertex) : VW'(first_vertex);
			S_ROOT:  rd0 = root_q;
			S_SCAN:  rd0 = top_nc_q;
			default: rd0 = VW'(first_vertex);
		endcase
	end

	always_comb begin
		head_we = 1'b0;
		head_wa = clr_q;
		head_wd = '0;
		tail_we = (state_q == S_LOAD2);
		nsib_we = 1'b0;
		nsib_wa = c_q;
		nsib_wd = '0;
		disc_we = 1'b0;
		disc_wa = clr_q;
		disc_wd = '0;
		fin_we  = 1'b0;
		fin_wa  = clr_q;
		fin_wd  = '0;
		stk_we  = push;
		unique case (state_q)
			S_CLEAR: begin
				head_we = clr_head_q;
				disc_we = 1'b1;
				fin_we  = 1'b1;
			end
			S_LOAD2: begin
				head_we = (head_rd_q == '0);
				head_wa = p_q;
				head_wd = c_q;
				nsib_we = (head_rd_q != '0);
				nsib_wa = tail_rd_q;
				nsib_wd = c_q;
			end
			S_LOAD3: begin
				nsib_we = 1'b1;
			end
			S_ROOT2: begin
				disc_we = 1'b1;
				disc_wa = root_q;
				disc_wd = time_q;
			end
			S_SCAN: begin
				fin_we = (top_nc_q == '0);
				fin_wa = top_v_q;
				fin_wd = time_q;
			end
			S_TEST: begin
				disc_we = push;
				disc_wa = top_nc_q;
				disc_wd = time_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[rd0];
	end

	always_ff @(posedge clk) begin
		if (tail_we) tail_mem[p_q] <= c_q;
		tail_rd_q <= tail_mem[rd0];
	end

	always_ff @(posedge clk) begin
		if (nsib_we) nsib_mem[nsib_wa] <= nsib_wd;
		nsib_rd_q <= nsib_mem[rd0];
	end

	always_ff @(posedge clk) begin
		if (disc_we) disc_mem[disc_wa] <= disc_wd;
		disc_rd0_q <= disc_mem[rd0];
		disc_rd1_q <= disc_mem[rd1];
	end

	always_ff @(posedge clk) begin
		if (fin_we) fin_mem[fin_wa] <= fin_wd;
		fin_rd0_q <= fin_mem[rd0];
		fin_rd1_q <= fin_mem[rd1];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[sp_q - VW'(1)] <= {top_v_q, nsib_rd_q};
		stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VTX_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			root_q     <= '0;
			c_q        <= '0;
			p_q        <= '0;
			clr_q      <= '0;
			clr_head_q <= 1'b1;
			time_q     <= TW'(1);
			sp_q       <= '0;
			top_v_q    <= '0;
			top_nc_q   <= '0;
			done_q     <= 1'b0;
			kind_q     <= KIND_RUN;
			anc_q      <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						c_q <= VW'(first_vertex);
						p_q <= VW'(second_vertex);
						unique case (cmd_t'(cmd))
							CMD_LOAD: begin
								if (rng(CW'(first_vertex), lc)) begin
									if (second_vertex == '0)
										root_q <= VW'(first_vertex);
									else if (rng(CW'(second_vertex), lc))
										state_q <= S_LOAD2;
								end
							end
							CMD_RUN: begin
								clr_q      <= '0;
								clr_head_q <= 1'b0;
								state_q    <= S_CLEAR;
							end
							CMD_QUERY: begin
								if (!rng(CW'(first_vertex), lc) ||
								    !rng(CW'(second_vertex), lc)) begin
									done_q <= 1'b1;
									kind_q <= KIND_QUERY;
									anc_q  <= 1'b0;
									err_q  <= 1'b1;
								end else begin
									state_q <= S_QUERY;
								end
							end
							CMD_NONE: ;
						endcase
					end
				end
				S_LOAD2: state_q <= S_LOAD3;
				S_LOAD3: state_q <= S_IDLE;
				S_QUERY: begin
					done_q  <= 1'b1;
					kind_q  <= KIND_QUERY;
					anc_q   <= (disc_rd1_q > disc_rd0_q) && (fin_rd0_q > fin_rd1_q);
					err_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					clr_q <= clr_q + VW'(1);
					if (clr_q == VW'(MAX_VERTICES)) begin
						time_q <= TW'(1);
						if (clr_head_q) begin
							clr_head_q <= 1'b0;
							state_q    <= S_IDLE;
						end else if (rng(CW'(root_q), lc)) begin
							state_q <= S_ROOT;
						end else begin
							done_q  <= 1'b1;
							kind_q  <= KIND_RUN;
							anc_q   <= 1'b0;
							err_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				S_ROOT: state_q <= S_ROOT2;
				S_ROOT2: begin
					time_q   <= time_q + TW'(1);
					top_v_q  <= root_q;
					top_nc_q <= head_rd_q;
					sp_q     <= VW'(1);
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (top_nc_q == '0) begin
						time_q <= time_q + TW'(1);
						sp_q   <= sp_q - VW'(1);
						if (sp_q == VW'(1)) begin
							done_q  <= 1'b1;
							kind_q  <= KIND_RUN;
							anc_q   <= 1'b0;
							err_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_POP;
						end
					end else begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					if (push) begin
						time_q   <= time_q + TW'(1);
						top_v_q  <= top_nc_q;
						top_nc_q <= head_rd_q;
						sp_q     <= sp_q + VW'(1);
					end else begin
						top_nc_q <= nsib_rd_q;
					end
					state_q <= S_SCAN;
				end
				S_POP: begin
					top_v_q  <= stk_rd_q[2*VW-1:VW];
					top_nc_q <= stk_rd_q[VW-1:0];
					state_q  <= S_SCAN;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_LOAD) |=> !done)
		else $error("load produced a result");

	a_err_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (kind == KIND_QUERY))
		else $error("range error on a traversal result");

	a_stack_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_TEST) |-> (sp_q != '0))
		else $error("walk step with empty stack");
`endif

endmodule
